// File: rtl/yield_curve_interpolator_assert.svh
// Assertion macros used by the checker file.
`ifndef YIELD_CURVE_INTERPOLATOR_ASSERT_SVH
`define YIELD_CURVE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication.
`define YCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yci assertion failed");

// Next-cycle implication.
`define YCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("yci assertion failed");

`endif

// File: rtl/yci_pkg.sv
package yci_pkg;

    localparam int YEARS_W  = 23;
    localparam int RATE_W   = 26;
    localparam int DISC_W   = 32;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;

    localparam logic [39:0] LN2_Q40 = 40'hB17217F7D1;
    localparam logic signed [RATE_W-1:0] MINUS_ONE_Q24 = -26'sd16777216;
    localparam logic [3:0] TAYLOR_LAST = 4'd14;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_BAD_MATURITY = 3'd1,
        ST_BAD_RATE     = 3'd2,
        ST_DUPLICATE    = 3'd3,
        ST_FULL         = 3'd4,
        ST_EMPTY        = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IMUL,
        S_IPREP,
        S_IDIV,
        S_ZR,
        S_AMUL,
        S_RPREP,
        S_RED,
        S_RFIN,
        S_TMUL,
        S_TDIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic valid;
        logic ins;
    } t_cell_ctl;

    typedef struct packed {
        logic lt;
        logic hit;
        logic first;
    } t_cell_stat;

endpackage

// File: rtl/yield_curve_interpolator.sv
// Yield curve interpolator.
// Request channel: start/busy. A request (i_mode, i_years, i_rate) is taken at a
// clock edge with start high and busy low. Modes: clear table, add point,
// query maturity, and a no-op code.
// Result channel: o_valid strobes for one cycle with o_status, o_zero_rate_out,
// o_discount and o_saturated; the receiver cannot stall it.
// Clear, add, no-op and rejected queries answer in the cycle after the request
// and leave busy low, so one such request per cycle is taken.
// A query runs on one shared datapath: a bit-serial division for the
// interpolation, range reduction by ln 2, and 13 Taylor steps (each one
// multiply, then a byte-wide divide that yields four quotient bytes). A flat
// query skips the interpolation, and the Taylor steps are skipped when the
// discount saturates or underflows; o_valid rises in the cycle busy falls.
// Curve points live in a row of cells kept in ascending maturity; an insert
// writes the new point and shifts the upper cells one place right together.
// Reset (i_rst_n low, synchronous) empties the table and returns to idle.
module yield_curve_interpolator #(
    parameter int MAX_POINTS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic [yci_pkg::MODE_W-1:0]           i_mode,
    input  logic [yci_pkg::YEARS_W-1:0]          i_years,
    input  logic signed [yci_pkg::RATE_W-1:0]    i_rate,
    output logic                                 busy,
    output logic                                 o_valid,
    output logic [yci_pkg::STATUS_W-1:0]         o_status,
    output logic signed [yci_pkg::RATE_W-1:0]    o_zero_rate_out,
    output logic [yci_pkg::DISC_W-1:0]           o_discount,
    output logic                                 o_saturated
);
    import yci_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_valid, n_valid;
    t_status                   r_status, n_status;
    logic signed [RATE_W-1:0]  r_zr_out, n_zr_out;
    logic [DISC_W-1:0]         r_disc, n_disc;
    logic                      r_sat, n_sat;

    logic [YEARS_W-1:0]        r_y, n_y;
    logic [YEARS_W-1:0]        r_ylo, n_ylo;
    logic [YEARS_W-1:0]        r_yhi, n_yhi;
    logic signed [RATE_W-1:0]  r_rlo, n_rlo;
    logic signed [RATE_W-1:0]  r_rhi, n_rhi;
    logic signed [RATE_W-1:0]  r_zr, n_zr;
    logic signed [50:0]        r_prod, n_prod;
    logic [YEARS_W-1:0]        r_den, n_den;
    logic [YEARS_W-1:0]        r_rem, n_rem;
    logic [26:0]               r_sh, n_sh;
    logic [26:0]               r_q, n_q;
    logic                      r_neg, n_neg;
    logic [4:0]                r_cnt, n_cnt;
    logic signed [49:0]        r_a, n_a;
    logic [48:0]               r_red_rem, n_red_rem;
    logic [47:0]               r_dsh, n_dsh;
    logic [8:0]                r_kq, n_kq;
    logic signed [10:0]        r_k, n_k;
    logic [31:0]               r_g, n_g;
    logic [31:0]               r_term, n_term;
    logic [33:0]               r_sum, n_sum;
    logic [3:0]                r_n, n_n;
    logic [31:0]               r_tp, n_tp;
    logic [3:0]                r_trem, n_trem;
    logic [23:0]               r_tq, n_tq;

    t_mode                     mode;
    logic                      accept;
    logic                      add_ok;
    logic                      dup;
    logic                      full;
    logic                      ins;

    t_cell_ctl                 ctl   [MAX_POINTS];
    t_cell_stat                stat  [MAX_POINTS];
    logic [YEARS_W-1:0]        c_year[MAX_POINTS];
    logic signed [RATE_W-1:0]  c_rate[MAX_POINTS];

    logic [YEARS_W-1:0]        sel_ylo, sel_yhi;
    logic [RATE_W-1:0]         sel_rlo, sel_rhi, sel_rlast;
    logic                      any_first;
    logic                      flat;
    logic signed [RATE_W-1:0]  flat_rate;

    assign mode   = t_mode'(i_mode);
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(MAX_POINTS));
    assign add_ok = (i_years != '0) && !(i_rate <= MINUS_ONE_Q24) && !dup && !full;
    assign ins    = accept && (mode == MODE_ADD) && add_ok;

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        assign ctl[g].valid = (CNT_W'(g) < r_count);
        assign ctl[g].ins   = ins;
        if (g == 0) begin : g_head
            yci_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl[g]),
                .i_left_lt   (1'b1),
                .i_key       (i_years),
                .i_rate_new  (i_rate),
                .i_left_year (i_years),
                .i_left_rate (i_rate),
                .o_year      (c_year[g]),
                .o_rate      (c_rate[g]),
                .o_stat      (stat[g])
            );
        end else begin : g_body
            yci_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl[g]),
                .i_left_lt   (stat[g-1].lt),
                .i_key       (i_years),
                .i_rate_new  (i_rate),
                .i_left_year (c_year[g-1]),
                .i_left_rate (c_rate[g-1]),
                .o_year      (c_year[g]),
                .o_rate      (c_rate[g]),
                .o_stat      (stat[g])
            );
        end
    end

    always_comb begin
        dup       = 1'b0;
        any_first = 1'b0;
        sel_ylo   = '0;
        sel_yhi   = '0;
        sel_rlo   = '0;
        sel_rhi   = '0;
        sel_rlast = '0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            dup       = dup | stat[i].hit;
            any_first = any_first | stat[i].first;
            sel_yhi   = sel_yhi | (stat[i].first ? c_year[i] : '0);
            sel_rhi   = sel_rhi | (stat[i].first ? c_rate[i] : '0);
            if (i + 1 < MAX_POINTS) begin
                sel_ylo   = sel_ylo | (stat[i+1].first ? c_year[i] : '0);
                sel_rlo   = sel_rlo | (stat[i+1].first ? c_rate[i] : '0);
                sel_rlast = sel_rlast | ((ctl[i].valid && !ctl[i+1].valid) ? c_rate[i] : '0);
            end else begin
                sel_rlast = sel_rlast | (ctl[i].valid ? c_rate[i] : '0);
            end
        end
        flat      = !any_first || stat[0].first;
        flat_rate = stat[0].first ? c_rate[0] : $signed(sel_rlast);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_zr_out  <= n_zr_out;
        r_disc    <= n_disc;
        r_sat     <= n_sat;
        r_y       <= n_y;
        r_ylo     <= n_ylo;
        r_yhi     <= n_yhi;
        r_rlo     <= n_rlo;
        r_rhi     <= n_rhi;
        r_zr      <= n_zr;
        r_prod    <= n_prod;
        r_den     <= n_den;
        r_rem     <= n_rem;
        r_sh      <= n_sh;
        r_q       <= n_q;
        r_neg     <= n_neg;
        r_cnt     <= n_cnt;
        r_a       <= n_a;
        r_red_rem <= n_red_rem;
        r_dsh     <= n_dsh;
        r_kq      <= n_kq;
        r_k       <= n_k;
        r_g       <= n_g;
        r_term    <= n_term;
        r_sum     <= n_sum;
        r_n       <= n_n;
        r_tp      <= n_tp;
        r_trem    <= n_trem;
        r_tq      <= n_tq;
    end

    always_comb begin
        logic signed [23:0] dy;
        logic signed [26:0] dr;
        logic [50:0]        pmag;
        logic [23:0]        trial;
        logic signed [27:0] qs;
        logic signed [27:0] zsum;
        logic signed [49:0] pa;
        logic signed [23:0] ysg;
        logic [49:0]        amag;
        logic [39:0]        f;
        logic signed [10:0] k;
        logic [4:0]         rem5;
        logic [3:0]         trem;
        logic [7:0]         qbyte;
        logic [7:0]         dbyte;
        logic [31:0]        term;
        logic [5:0]         shamt;

        n_state   = r_state;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_zr_out  = r_zr_out;
        n_disc    = r_disc;
        n_sat     = r_sat;
        n_y       = r_y;
        n_ylo     = r_ylo;
        n_yhi     = r_yhi;
        n_rlo     = r_rlo;
        n_rhi     = r_rhi;
        n_zr      = r_zr;
        n_prod    = r_prod;
        n_den     = r_den;
        n_rem     = r_rem;
        n_sh      = r_sh;
        n_q       = r_q;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        n_a       = r_a;
        n_red_rem = r_red_rem;
        n_dsh     = r_dsh;
        n_kq      = r_kq;
        n_k       = r_k;
        n_g       = r_g;
        n_term    = r_term;
        n_sum     = r_sum;
        n_n       = r_n;
        n_tp      = r_tp;
        n_trem    = r_trem;
        n_tq      = r_tq;

        dy    = $signed({1'b0, r_y - r_ylo});
        dr    = 27'(r_rhi) - 27'(r_rlo);
        pmag  = r_prod[50] ? $unsigned(-r_prod) : $unsigned(r_prod);
        trial = {r_rem, r_sh[26]};
        qs    = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        zsum  = 28'(r_rlo) + qs;
        ysg   = $signed({1'b0, r_y});
        pa    = r_zr * ysg;
        amag  = r_a[49] ? $unsigned(-r_a) : $unsigned(r_a);
        if (r_neg && (r_red_rem != '0)) begin
            k = -(11'(r_kq) + 11'sd1);
            f = LN2_Q40 - r_red_rem[39:0];
        end else if (r_neg) begin
            k = -11'(r_kq);
            f = '0;
        end else begin
            k = 11'(r_kq);
            f = r_red_rem[39:0];
        end
        trem  = r_trem;
        dbyte = r_tp[31:24];
        qbyte = '0;
        for (int j = 7; j >= 0; j--) begin
            rem5 = {trem, dbyte[j]};
            if (rem5 >= {1'b0, r_n}) begin
                rem5     = rem5 - {1'b0, r_n};
                qbyte[j] = 1'b1;
            end
            trem = rem5[3:0];
        end
        term  = {r_tq, qbyte};
        shamt = 6'(11'sd8 - r_k);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_zr_out = '0;
                    n_disc   = '0;
                    n_sat    = 1'b0;
                    case (mode)
                        MODE_CLEAR: n_count = '0;
                        MODE_ADD: begin
                            if (i_years == '0) begin
                                n_status = ST_BAD_MATURITY;
                            end else if (i_rate <= MINUS_ONE_Q24) begin
                                n_status = ST_BAD_RATE;
                            end else if (dup) begin
                                n_status = ST_DUPLICATE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        MODE_QUERY: begin
                            if (i_years == '0) begin
                                n_status = ST_BAD_MATURITY;
                            end else if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_y     = i_years;
                                n_ylo   = sel_ylo;
                                n_yhi   = sel_yhi;
                                n_rlo   = $signed(sel_rlo);
                                n_rhi   = $signed(sel_rhi);
                                n_zr    = flat_rate;
                                n_state = flat ? S_AMUL : S_IMUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_IMUL: begin
                n_prod  = dy * dr;
                n_den   = r_yhi - r_ylo;
                n_state = S_IPREP;
            end
            S_IPREP: begin
                n_neg   = r_prod[50];
                n_rem   = {1'b0, pmag[48:27]};
                n_sh    = pmag[26:0];
                n_q     = '0;
                n_cnt   = 5'd26;
                n_state = S_IDIV;
            end
            S_IDIV: begin
                if (trial >= {1'b0, r_den}) begin
                    n_rem = 23'(trial - {1'b0, r_den});
                    n_q   = {r_q[25:0], 1'b1};
                end else begin
                    n_rem = trial[22:0];
                    n_q   = {r_q[25:0], 1'b0};
                end
                n_sh  = {r_sh[25:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_ZR;
                end
            end
            S_ZR: begin
                n_zr    = zsum[RATE_W-1:0];
                n_state = S_AMUL;
            end
            S_AMUL: begin
                n_a     = -pa;
                n_state = S_RPREP;
            end
            S_RPREP: begin
                n_neg     = r_a[49];
                n_red_rem = amag[48:0];
                n_dsh     = {LN2_Q40, 8'd0};
                n_kq      = '0;
                n_cnt     = 5'd8;
                n_state   = S_RED;
            end
            S_RED: begin
                if (r_red_rem >= {1'b0, r_dsh}) begin
                    n_red_rem = r_red_rem - {1'b0, r_dsh};
                    n_kq      = {r_kq[7:0], 1'b1};
                end else begin
                    n_kq      = {r_kq[7:0], 1'b0};
                end
                n_dsh = {1'b0, r_dsh[47:1]};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_RFIN;
                end
            end
            S_RFIN: begin
                n_k    = k;
                n_g    = f[39:8];
                n_term = f[39:8];
                n_sum  = 34'h1_0000_0000 + 34'(f[39:8]);
                n_n    = 4'd2;
                if (k >= 11'sd8 || k <= -11'sd32) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_TMUL;
                end
            end
            S_TMUL: begin
                n_tp    = 32'((64'(r_term) * 64'(r_g)) >> 32);
                n_trem  = '0;
                n_tq    = '0;
                n_cnt   = 5'd3;
                n_state = S_TDIV;
            end
            S_TDIV: begin
                n_trem = trem;
                n_tq   = {r_tq[15:0], qbyte};
                n_tp   = {r_tp[23:0], 8'd0};
                n_cnt  = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_term = term;
                    n_sum  = r_sum + 34'(term);
                    n_n    = r_n + 4'd1;
                    n_state = (r_n == TAYLOR_LAST) ? S_FIN : S_TMUL;
                end
            end
            S_FIN: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_zr_out = r_zr;
                if (r_k >= 11'sd8) begin
                    n_disc = '1;
                    n_sat  = 1'b1;
                end else if (r_k <= -11'sd32) begin
                    n_disc = '0;
                    n_sat  = 1'b0;
                end else begin
                    n_disc = 32'(r_sum >> shamt);
                    n_sat  = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_zero_rate_out = r_zr_out;
    assign o_discount      = r_disc;
    assign o_saturated     = r_sat;

endmodule

// File: rtl/yci_cell.sv
module yci_cell (
    input  logic                                 i_clk,
    input  yci_pkg::t_cell_ctl                   i_ctl,
    input  logic                                 i_left_lt,
    input  logic [yci_pkg::YEARS_W-1:0]          i_key,
    input  logic signed [yci_pkg::RATE_W-1:0]    i_rate_new,
    input  logic [yci_pkg::YEARS_W-1:0]          i_left_year,
    input  logic signed [yci_pkg::RATE_W-1:0]    i_left_rate,
    output logic [yci_pkg::YEARS_W-1:0]          o_year,
    output logic signed [yci_pkg::RATE_W-1:0]    o_rate,
    output yci_pkg::t_cell_stat                  o_stat
);
    import yci_pkg::*;

    logic [YEARS_W-1:0]        r_year;
    logic signed [RATE_W-1:0]  r_rate;
    logic                      lt_own;

    assign lt_own = i_ctl.valid && (r_year < i_key);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (!lt_own && i_left_lt) begin
                r_year <= i_key;
                r_rate <= i_rate_new;
            end else if (!i_left_lt) begin
                r_year <= i_left_year;
                r_rate <= i_left_rate;
            end
        end
    end

    assign o_year       = r_year;
    assign o_rate       = r_rate;
    assign o_stat.lt    = lt_own;
    assign o_stat.hit   = i_ctl.valid && (r_year == i_key);
    assign o_stat.first = i_ctl.valid && !lt_own && i_left_lt;

endmodule

// File: rtl/yci_checker.sv
`include "yield_curve_interpolator_assert.svh"

module yci_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic [yci_pkg::MODE_W-1:0]           i_mode,
    input logic                                 busy,
    input logic                                 o_valid,
    input logic [yci_pkg::STATUS_W-1:0]         o_status,
    input logic signed [yci_pkg::RATE_W-1:0]    o_zero_rate_out,
    input logic [yci_pkg::DISC_W-1:0]           o_discount,
    input logic                                 o_saturated
);
    import yci_pkg::*;

    logic fields_clear;
    logic quick_req;

    assign fields_clear = (o_zero_rate_out == '0) && (o_discount == '0) && !o_saturated;
    assign quick_req    = start && !busy && (i_mode != MODE_QUERY);

    `YCI_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid, (o_status <= ST_EMPTY))
    `YCI_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), fields_clear)
    `YCI_ASSERT_IMP(a_sat_clamp, i_clk, i_rst_n, o_valid && o_saturated, (o_discount == '1))
    `YCI_ASSERT_NXT(a_quick_answer, i_clk, i_rst_n, quick_req, o_valid && !busy)
    `YCI_ASSERT_NXT(a_no_spurious, i_clk, i_rst_n, !busy && !start, !o_valid)

endmodule

bind yield_curve_interpolator yci_checker u_yci_checker (.*);
